// File: hdl/sts_pkg.sv
// shared constants and types for the stencil triangular solve block
package sts_pkg;

    // default sizes
    localparam int MaxTaps     = 7;
    localparam int MaxRows     = 64;
    localparam int MaxColumns  = 64;
    localparam int WindowDepth = 16384;

    // field widths
    localparam int DataW   = 32;
    localparam int PlaneW  = 16;
    localparam int ExtW    = 9;
    localparam int AreaW   = 18;
    localparam int DistW   = 22;
    localparam int OffW    = 9;
    localparam int AccW    = 42;
    localparam int FracW   = 24;

    // register map, byte address is 8 * index
    typedef enum logic [2:0] {
        REG_PLANES  = 3'd0,
        REG_ROWS    = 3'd1,
        REG_COLUMNS = 3'd2,
        REG_TAPS    = 3'd3,
        REG_OFFSETS = 3'd4
    } t_reg;

    // grid geometry handed to every lane
    typedef struct packed {
        logic [PlaneW-1:0] planes;
        logic [ExtW-1:0]   rows;
        logic [ExtW-1:0]   columns;
        logic [AreaW-1:0]  area;
    } t_geom;

endpackage

// File: hdl/sts_ram.sv
// generic single write, single registered read memory
module sts_ram #(
    parameter int Width = 32,
    parameter int Depth = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/sts_lane.sv
// one tap lane: causality, grid bounds, scan distance and window address
module sts_lane #(
    parameter int MAX_ROWS     = sts_pkg::MaxRows,
    parameter int MAX_COLUMNS  = sts_pkg::MaxColumns,
    parameter int WINDOW_DEPTH = sts_pkg::WindowDepth
) (
    input  logic [sts_pkg::OffW-1:0]                         i_offset,
    input  logic                                             i_enable,
    input  sts_pkg::t_geom                                   i_geom,
    input  logic [sts_pkg::PlaneW-1:0]                       i_plane,
    input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] i_row,
    input  logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] i_col,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]                  i_wptr,
    output logic                                             o_ok,
    output logic [$clog2(WINDOW_DEPTH)-1:0]                  o_addr
);

    localparam int DW = sts_pkg::DistW;

    logic signed [2:0]      di, dj, dk;
    logic                   causal;
    logic signed [17:0]     ti;
    logic signed [9:0]      tj, tk;
    logic                   in_grid;
    logic signed [DW-1:0]   dpos, back_dist, a;

    always_comb begin
        di = $signed(i_offset[2:0]);
        dj = $signed(i_offset[5:3]);
        dk = $signed(i_offset[8:6]);
        // strictly earlier in scan order
        causal = (di < 0) || ((di == 0) && ((dj < 0) || ((dj == 0) && (dk < 0))));
        // neighbor position and bounds
        ti = $signed({2'b00, i_plane}) + 18'(di);
        tj = $signed({1'b0, 9'(i_row)}) + 10'(dj);
        tk = $signed({1'b0, 9'(i_col)}) + 10'(dk);
        in_grid = (ti >= 0) && (ti < $signed({2'b00, i_geom.planes}))
               && (tj >= 0) && (tj < $signed({1'b0, i_geom.rows}))
               && (tk >= 0) && (tk < $signed({1'b0, i_geom.columns}));
        // scan distance back to the neighbor
        dpos = DW'(di) * $signed({{(DW-sts_pkg::AreaW){1'b0}}, i_geom.area})
             + DW'(dj) * $signed({{(DW-sts_pkg::ExtW){1'b0}}, i_geom.columns})
             + DW'(dk);
        back_dist = -dpos;
        // circular window address
        a = $signed({{(DW-$clog2(WINDOW_DEPTH)){1'b0}}, i_wptr}) - back_dist;
        if (a < 0) begin
            a = a + DW'(WINDOW_DEPTH);
        end
        o_ok   = i_enable && causal && in_grid && (back_dist > 0)
              && (back_dist <= DW'(WINDOW_DEPTH));
        o_addr = a[$clog2(WINDOW_DEPTH)-1:0];
    end

endmodule

// File: hdl/stencil_triangular_solve.sv
// stencil triangular solve: forward substitution over a 3D grid
// sequence: accept in idle, one issue slot per tap lane, then drain, then write
// a new point is taken only in idle, one window read per tap; a waiting result holds the write
// taps of all lanes are evaluated in parallel at accept, then read and accumulated in order
// reset: synchronous active low, resets control, indices, window pointer and config registers
// the window memory is not cleared; entries hold garbage until written
module stencil_triangular_solve #(
    parameter int MAX_TAPS     = sts_pkg::MaxTaps,
    parameter int MAX_ROWS     = sts_pkg::MaxRows,
    parameter int MAX_COLUMNS  = sts_pkg::MaxColumns,
    parameter int WINDOW_DEPTH = sts_pkg::WindowDepth
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // rhs_value, coef_0 .. coef_6 from bit 0 up, 32 bits each
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sts_pkg::DataW*8-1:0]     s_axis_tdata,
    // solution_value
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sts_pkg::DataW-1:0]       m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [5:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int RW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int CW = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
    localparam int TW = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
    localparam int DW = sts_pkg::DataW;
    localparam int XW = sts_pkg::AccW;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_WRITE} t_state;

    logic [15:0]        r_planes;
    logic [6:0]         r_rows, r_cols;
    logic [2:0]         r_taps;
    logic [62:0]        r_offsets;
    t_state             r_state;
    logic [15:0]        r_plane;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [AW-1:0]      r_wptr;
    logic [TW-1:0]      r_t;
    logic [1:0]         r_drain;
    logic               r_tap_ok [MAX_TAPS];
    logic [AW-1:0]      r_tap_addr [MAX_TAPS];
    logic [DW-1:0]      r_coef [MAX_TAPS];
    logic signed [XW-1:0] r_acc;
    logic               r_rd_v, r_pv;
    logic [TW-1:0]      r_rd_t;
    logic signed [63:0] r_prod;
    logic               r_out_v, r_out_last;
    logic [DW-1:0]      r_out_data;

    logic               lane_ok [MAX_TAPS];
    logic [AW-1:0]      lane_addr [MAX_TAPS];
    sts_pkg::t_geom     geom;
    logic [2:0]         taps_eff;
    logic [DW-1:0]      rd_data;
    logic               wr_en;
    logic [DW-1:0]      sat;
    logic               done;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic signed [63:0] rnd;
    logic [sts_pkg::ExtW-1:0] kp1, jp1;
    logic [16:0]        ip1;

    // effective grid geometry
    always_comb begin
        geom.planes  = (r_planes == '0) ? 16'd1 : r_planes;
        geom.rows    = (r_rows == '0) ? 9'd1
                     : (9'(r_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(r_rows);
        geom.columns = (r_cols == '0) ? 9'd1
                     : (9'(r_cols) > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : 9'(r_cols);
        geom.area    = 18'(geom.rows) * 18'(geom.columns);
        taps_eff     = (32'(r_taps) > MAX_TAPS) ? 3'(MAX_TAPS) : r_taps;
    end

    // tap lanes
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_lane
        sts_lane #(
            .MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .WINDOW_DEPTH(WINDOW_DEPTH)
        ) u_lane (
            .i_offset (r_offsets[9*g +: 9]),
            .i_enable (32'(g) < 32'(taps_eff)),
            .i_geom   (geom),
            .i_plane  (r_plane),
            .i_row    (r_row),
            .i_col    (r_col),
            .i_wptr   (r_wptr),
            .o_ok     (lane_ok[g]),
            .o_addr   (lane_addr[g])
        );
    end

    // solution window
    sts_ram #(.Width(DW), .Depth(WINDOW_DEPTH)) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (sat),
        .i_rd_addr (r_tap_addr[r_t]),
        .o_rd_data (rd_data)
    );

    // merge: rounding, saturation, scan position
    always_comb begin
        rnd = (r_prod + 64'sd8388608) >>> sts_pkg::FracW;
        if (r_acc > $signed(XW'(32'h7fffffff))) begin
            sat = 32'h7fffffff;
        end else if (r_acc < -$signed(XW'(33'h080000000))) begin
            sat = 32'h80000000;
        end else begin
            sat = r_acc[DW-1:0];
        end
        kp1  = 9'(r_col) + 9'd1;
        jp1  = 9'(r_row) + 9'd1;
        ip1  = 17'(r_plane) + 17'd1;
        done = (kp1 >= geom.columns) && (jp1 >= geom.rows) && (ip1 >= 17'(geom.planes));
        wr_en = (r_state == S_WRITE) && (!r_out_v || m_axis_tready);
    end

    // configuration port
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            sts_pkg::REG_PLANES:  prdata = 64'(r_planes);
            sts_pkg::REG_ROWS:    prdata = 64'(r_rows);
            sts_pkg::REG_COLUMNS: prdata = 64'(r_cols);
            sts_pkg::REG_TAPS:    prdata = 64'(r_taps);
            sts_pkg::REG_OFFSETS: prdata = 64'(r_offsets);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes  <= 16'd1;
            r_rows    <= 7'd1;
            r_cols    <= 7'd1;
            r_taps    <= '0;
            r_offsets <= '0;
        end else if (cfg_wr && paddr[2:0] == 3'd0) begin
            unique case (cfg_idx)
                sts_pkg::REG_PLANES:  r_planes  <= pwdata[15:0];
                sts_pkg::REG_ROWS:    r_rows    <= pwdata[6:0];
                sts_pkg::REG_COLUMNS: r_cols    <= pwdata[6:0];
                sts_pkg::REG_TAPS:    r_taps    <= pwdata[2:0];
                sts_pkg::REG_OFFSETS: r_offsets <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // sequencer, tap pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_wptr  <= '0;
            r_t     <= '0;
            r_drain <= '0;
            r_rd_v  <= 1'b0;
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (wr_en) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            // window data to product, product to accumulator
            r_pv   <= r_rd_v;
            r_prod <= $signed(r_coef[r_rd_t]) * $signed(rd_data);
            if (r_pv) begin
                r_acc <= r_acc - XW'(rnd);
            end
            r_rd_v <= (r_state == S_ISSUE) && r_tap_ok[r_t];
            r_rd_t <= r_t;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_acc <= XW'($signed(s_axis_tdata[DW-1:0]));
                        for (int t = 0; t < MAX_TAPS; t++) begin
                            r_coef[t]     <= s_axis_tdata[DW*(t+1) +: DW];
                            r_tap_ok[t]   <= lane_ok[t];
                            r_tap_addr[t] <= lane_addr[t];
                        end
                        r_t     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (32'(r_t) == MAX_TAPS - 1) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (wr_en) begin
                        r_out_data <= sat;
                        r_out_last <= done;
                        r_wptr <= (32'(r_wptr) == WINDOW_DEPTH - 1) ? '0 : r_wptr + 1'b1;
                        if (kp1 < geom.columns) begin
                            r_col <= r_col + 1'b1;
                        end else begin
                            r_col <= '0;
                            if (jp1 < geom.rows) begin
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_row   <= '0;
                                r_plane <= (ip1 < 17'(geom.planes)) ? r_plane + 16'd1 : '0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // tap pipeline is empty when the solution is written
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (!r_rd_v && !r_pv))
        else $error("tap pipeline not drained at write");

    // a new result only comes from the write state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_WRITE))
        else $error("result raised outside write state");

    // window pointer moves exactly on a window write
    a_wptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> $stable(r_wptr))
        else $error("window pointer moved without write");

endmodule
